@@ rtl/tkvc_pkg.sv @@
// Shared codes, configuration constants and control types for the TTL key/value cache.
package tkvc_pkg;

   // request codes carried in req_type
   localparam int REQ_TYPE_BITS = 3;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_TICK   = 3'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_SET    = 3'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_GET    = 3'd2;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_REMOVE = 3'd3;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_CLEAR  = 3'd4;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ENTRIES  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FALLBACK_TTL = 1'd1;

   localparam int MAX_ENTRIES_BITS = 5;
   localparam int TTL_BITS         = 16;
   localparam logic [MAX_ENTRIES_BITS-1:0] MAX_ENTRIES_RESET  = 5'd16;
   localparam logic [TTL_BITS-1:0]         FALLBACK_TTL_RESET = 16'd60;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACT,
      ST_INSERT,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic capture;    // latch request and key match vector
      logic act;        // run the request against the table
      logic insert;     // set: evict if full, write the new entry
      logic hold;       // park the result while the output register is busy
      logic load_out;   // load the live result into the output register
      logic load_hold;  // load the parked result into the output register
   } cmd_type;

   typedef struct packed {
      logic [REQ_TYPE_BITS-1:0] op;
   } status_type;

endpackage

@@ rtl/tkvc_ifs.sv @@
// Request and response channel interfaces of the TTL key/value cache.
interface tkvc_req_if
   import tkvc_pkg::*;
#(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
);
   logic                     valid;
   logic                     ready;
   logic [REQ_TYPE_BITS-1:0] req_type;
   logic [KEY_BITS-1:0]      key;
   logic [VALUE_BITS-1:0]    value;
   logic [TTL_BITS-1:0]      ttl;

   modport source (output valid, req_type, key, value, ttl, input ready);
   modport sink (input valid, req_type, key, value, ttl, output ready);
endinterface

interface tkvc_rsp_if #(
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 5
);
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [VALUE_BITS-1:0] read_value;
   logic                  evicted;
   logic [COUNT_BITS-1:0] entry_count;

   modport source (output valid, hit, read_value, evicted, entry_count, input ready);
   modport sink (input valid, hit, read_value, evicted, entry_count, output ready);
endinterface

@@ rtl/ttl_key_value_cache_core.sv @@
// Top level of the TTL key/value cache: controller, datapath and channel hookup.
//
//   channel  | dir | transfer contents
//   ---------+-----+-------------------------------------------------
//   req_bus  | in  | req_type, key, value, ttl
//   rsp_bus  | out | hit, read_value, evicted, entry_count
//   csr_*    | in  | write enable, index (0 max_entries, 1 fallback ttl), data
//
// Tick, get, remove, clear and unknown codes pass through capture and act: key match is registered
// at the request transfer, the table update runs in the next cycle. A set adds an insert
// step that evicts the rank-zero entry if the table is full and writes the new one.
// Reset clears valid bits, entry count and time and restores configuration.
// A response waiting on rsp_bus does not block the next request; a second
// finished result is parked until the output register frees up.
module ttl_key_value_cache_core
   import tkvc_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   parameter int TIME_BITS  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   tkvc_req_if.sink                  req_bus,
   tkvc_rsp_if.source                rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   cmd_type    cmd;
   status_type status;

   tkvc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tkvc_datapath #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_bus.req_type),
      .req_key         (req_bus.key),
      .req_value       (req_bus.value),
      .req_ttl         (req_bus.ttl),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_hit         (rsp_bus.hit),
      .rsp_read_value  (rsp_bus.read_value),
      .rsp_evicted     (rsp_bus.evicted),
      .rsp_entry_count (rsp_bus.entry_count)
   );

   // one request in flight: no second transfer right after the first
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while previous one still in the table update");

   a_hit_not_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.hit && rsp_bus.evicted))
      else $error("response reports both hit and eviction");

   a_evict_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.evicted) |-> (rsp_bus.entry_count != '0))
      else $error("eviction reported with empty table");

   a_value_on_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.hit) |-> (rsp_bus.read_value == '0))
      else $error("nonzero read value without a hit");

endmodule

@@ rtl/tkvc_controller.sv @@
// Sequencer: accept, act, optional insert, then result hand-off.
module tkvc_controller
   import tkvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      finish       = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ACT;
            end
         end
         ST_ACT: begin
            cmd.act = 1'b1;
            if (status.op == REQ_SET) begin
               state_in = ST_INSERT;
            end else begin
               finish = 1'b1;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            finish     = 1'b1;
         end
         ST_WAIT: begin
            if (out_free) begin
               cmd.load_hold = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // result goes straight out if the output register frees up, else it is parked
      if (finish) begin
         if (out_free) begin
            cmd.load_out = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            cmd.hold = 1'b1;
            state_in = ST_WAIT;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/tkvc_datapath.sv @@
// Entry table, time counter, configuration registers and result registers.
module tkvc_datapath
   import tkvc_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   parameter int TIME_BITS  = 32,
   parameter int COUNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic [REQ_TYPE_BITS-1:0]  req_type,
   input  logic [KEY_BITS-1:0]       req_key,
   input  logic [VALUE_BITS-1:0]     req_value,
   input  logic [TTL_BITS-1:0]       req_ttl,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                      rsp_hit,
   output logic [VALUE_BITS-1:0]     rsp_read_value,
   output logic                      rsp_evicted,
   output logic [COUNT_BITS-1:0]     rsp_entry_count
);

   localparam int RANK_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_BITS  = (COUNT_BITS > MAX_ENTRIES_BITS) ? COUNT_BITS : MAX_ENTRIES_BITS;
   localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
   localparam logic [CAP_BITS-1:0]  CAP_DEPTH = CAP_BITS'(DEPTH);
   localparam logic [CAP_BITS-1:0]  CAP_ONE   = CAP_BITS'(1);

   // table
   logic [DEPTH-1:0]      valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff    [DEPTH];
   logic [VALUE_BITS-1:0] value_ff  [DEPTH];
   logic [TIME_BITS-1:0]  expiry_ff [DEPTH];
   logic [RANK_BITS-1:0]  rank_ff   [DEPTH];
   logic [RANK_BITS-1:0]  rank_in   [DEPTH];
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;

   // configuration
   logic [MAX_ENTRIES_BITS-1:0] max_entries_ff;
   logic [TTL_BITS-1:0]         fallback_ttl_ff;

   // captured request
   logic [REQ_TYPE_BITS-1:0] op_ff;
   logic [KEY_BITS-1:0]      rkey_ff;
   logic [VALUE_BITS-1:0]    rvalue_ff;
   logic [TTL_BITS-1:0]      rttl_ff;
   logic [DEPTH-1:0]         match_ff, match_in;
   logic                     hit_any_ff;

   // result path
   logic                  res_hit, res_evicted;
   logic [VALUE_BITS-1:0] res_value;
   logic                  out_hit_ff, out_evicted_ff, hold_hit_ff, hold_evicted_ff;
   logic [VALUE_BITS-1:0] out_value_ff, hold_value_ff;
   logic [COUNT_BITS-1:0] out_count_ff, hold_count_ff;

   // working signals
   logic [RANK_BITS-1:0]  sel_rank;
   logic [TIME_BITS-1:0]  sel_expiry;
   logic [VALUE_BITS-1:0] sel_value;
   logic                  drop, evict;
   logic [DEPTH-1:0]      oldest_vec, free_vec, first_free, wr_vec;
   logic [TTL_BITS-1:0]   ttl_eff;
   logic [TIME_BITS:0]    exp_sum;
   logic [TIME_BITS-1:0]  exp_new;
   logic [CAP_BITS-1:0]   max_ext, cap;
   logic                  cap_hit;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = valid_ff[i] && (key_ff[i] == req_key);
      end
   end

   always_comb begin
      sel_rank   = '0;
      sel_expiry = '0;
      sel_value  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (match_ff[i]) begin
            sel_rank   = sel_rank | rank_ff[i];
            sel_expiry = sel_expiry | expiry_ff[i];
            sel_value  = sel_value | value_ff[i];
         end
         oldest_vec[i] = valid_ff[i] && (rank_ff[i] == '0);
      end
      free_vec   = ~valid_ff;
      first_free = free_vec & (~free_vec + 1'b1);

      max_ext = CAP_BITS'(max_entries_ff);
      if (max_ext == '0) begin
         cap = CAP_ONE;
      end else if (max_ext > CAP_DEPTH) begin
         cap = CAP_DEPTH;
      end else begin
         cap = max_ext;
      end
      cap_hit = CAP_BITS'(count_ff) >= cap;

      ttl_eff = (rttl_ff != '0) ? rttl_ff : fallback_ttl_ff;
      exp_sum = {1'b0, now_ff} + (TIME_BITS + 1)'(ttl_eff);
      exp_new = exp_sum[TIME_BITS] ? TIME_MAX : exp_sum[TIME_BITS-1:0];

      valid_in    = valid_ff;
      rank_in     = rank_ff;
      count_in    = count_ff;
      now_in      = now_ff;
      wr_vec      = '0;
      drop        = 1'b0;
      evict       = 1'b0;
      res_hit     = 1'b0;
      res_value   = '0;
      res_evicted = 1'b0;

      if (cmd.act) begin
         case (op_ff)
            REQ_TICK: begin
               now_in = (now_ff == TIME_MAX) ? now_ff : now_ff + 1'b1;
            end
            REQ_SET: begin
               drop = hit_any_ff;
            end
            REQ_GET: begin
               if (hit_any_ff) begin
                  if (now_ff > sel_expiry) begin
                     drop = 1'b1;
                  end else begin
                     res_hit   = 1'b1;
                     res_value = sel_value;
                  end
               end
            end
            REQ_REMOVE: begin
               drop = hit_any_ff;
            end
            REQ_CLEAR: begin
               valid_in = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      // removing one entry closes the gap in the insertion order
      if (drop) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (match_ff[i]) begin
               valid_in[i] = 1'b0;
            end else if (valid_ff[i] && (rank_ff[i] > sel_rank)) begin
               rank_in[i] = rank_ff[i] - 1'b1;
            end
         end
         count_in = count_ff - 1'b1;
      end

      // ranks stay dense, so the oldest entry is the one at rank zero
      if (cmd.insert) begin
         evict  = cap_hit;
         wr_vec = evict ? oldest_vec : first_free;
         for (int i = 0; i < DEPTH; i++) begin
            if (evict && valid_ff[i] && !oldest_vec[i]) begin
               rank_in[i] = rank_ff[i] - 1'b1;
            end
            if (wr_vec[i]) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = evict ? RANK_BITS'(count_ff - 1'b1) : RANK_BITS'(count_ff);
            end
         end
         count_in    = evict ? count_ff : count_ff + 1'b1;
         res_evicted = evict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= '0;
         count_ff        <= '0;
         now_ff          <= '0;
         max_entries_ff  <= MAX_ENTRIES_RESET;
         fallback_ttl_ff <= FALLBACK_TTL_RESET;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         now_ff   <= now_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAX_ENTRIES:  max_entries_ff  <= csr_wdata[MAX_ENTRIES_BITS-1:0];
               CSR_FALLBACK_TTL: fallback_ttl_ff <= csr_wdata[TTL_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_type;
         rkey_ff    <= req_key;
         rvalue_ff  <= req_value;
         rttl_ff    <= req_ttl;
         match_ff   <= match_in;
         hit_any_ff <= |match_in;
      end
      rank_ff <= rank_in;
      for (int i = 0; i < DEPTH; i++) begin
         if (wr_vec[i]) begin
            key_ff[i]    <= rkey_ff;
            value_ff[i]  <= rvalue_ff;
            expiry_ff[i] <= exp_new;
         end
      end
      if (cmd.hold) begin
         hold_hit_ff     <= res_hit;
         hold_value_ff   <= res_value;
         hold_evicted_ff <= res_evicted;
         hold_count_ff   <= count_in;
      end
      if (cmd.load_out) begin
         out_hit_ff     <= res_hit;
         out_value_ff   <= res_value;
         out_evicted_ff <= res_evicted;
         out_count_ff   <= count_in;
      end else if (cmd.load_hold) begin
         out_hit_ff     <= hold_hit_ff;
         out_value_ff   <= hold_value_ff;
         out_evicted_ff <= hold_evicted_ff;
         out_count_ff   <= hold_count_ff;
      end
   end

   assign status.op       = op_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_read_value  = out_value_ff;
   assign rsp_evicted     = out_evicted_ff;
   assign rsp_entry_count = out_count_ff;

endmodule

@@ test/ttl_key_value_cache_core_tb.sv @@
// Self-checking testbench for the TTL key/value cache: directed table, random phases, scoreboard.
module ttl_key_value_cache_core_tb
   import tkvc_pkg::*;
();

   localparam int DEPTH = 16;

   // reserved request codes, the block must treat them as no-ops
   localparam logic [REQ_TYPE_BITS-1:0] REQ_RSVD5 = 3'd5;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_RSVD6 = 3'd6;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_RSVD7 = 3'd7;

   typedef struct packed {
      logic [REQ_TYPE_BITS-1:0] op;
      logic [31:0]              key;
      logic [31:0]              value;
      logic [TTL_BITS-1:0]      ttl;
   } req_item_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [4:0]  entry_count;
   } rsp_item_type;

   typedef struct packed {
      req_item_type req;
      logic         typed;
      rsp_item_type rsp;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   tkvc_req_if #(.KEY_BITS(32), .VALUE_BITS(32)) req_bus ();
   tkvc_rsp_if #(.VALUE_BITS(32), .COUNT_BITS(5)) rsp_bus ();

   ttl_key_value_cache_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // cache shadow state
   logic        cache_valid  [DEPTH];
   logic [31:0] cache_key    [DEPTH];
   logic [31:0] cache_value  [DEPTH];
   logic [31:0] cache_expiry [DEPTH];
   int          cache_rank   [DEPTH];
   int          cache_count;
   logic [31:0] now_ticks;
   logic [4:0]  max_entries;
   logic [15:0] fallback_ttl;

   rsp_item_type expected_rsp_q [$];
   rsp_item_type got_rsp;
   rsp_item_type want_rsp;
   int           mismatch_count = 0;
   int           src_idle_pct;
   int           snk_idle_pct;
   logic         hold_rsp;
   logic [31:0]  key_pool [24];

   // expected values typed in where they follow directly from reset config (16 entries, ttl 60)
   directed_row_type directed_rows [25] = '{
      '{'{REQ_GET,    32'd5,         32'd0,         16'd0},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd0}},
      '{'{REQ_SET,    32'd0,         32'hFFFF_FFFF, 16'd0},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd1}},
      '{'{REQ_SET,    32'hFFFF_FFFF, 32'd0,         16'hFFFF},  1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd2}},
      '{'{REQ_GET,    32'd0,         32'd0,         16'd0},     1'b1,
        '{1'b1, 32'hFFFF_FFFF, 1'b0, 5'd2}},
      '{'{REQ_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF},  1'b1,
        '{1'b1, 32'd0, 1'b0, 5'd2}},
      '{'{REQ_SET,    32'd7,         32'h1234_5678, 16'd1},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd3}},
      '{'{REQ_TICK,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF},  1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd3}},
      // expiry equals now: still a hit
      '{'{REQ_GET,    32'd7,         32'd0,         16'd0},     1'b1,
        '{1'b1, 32'h1234_5678, 1'b0, 5'd3}},
      '{'{REQ_TICK,   32'd0,         32'd0,         16'd0},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd3}},
      // now past expiry: get drops the entry and misses
      '{'{REQ_GET,    32'd7,         32'd0,         16'd0},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd2}},
      '{'{REQ_REMOVE, 32'd9,         32'd0,         16'd0},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd2}},
      // same key set replaces, no eviction
      '{'{REQ_SET,    32'd0,         32'hA5A5_A5A5, 16'd3},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd2}},
      '{'{REQ_GET,    32'd0,         32'd0,         16'd0},     1'b1,
        '{1'b1, 32'hA5A5_A5A5, 1'b0, 5'd2}},
      '{'{REQ_REMOVE, 32'd0,         32'd0,         16'd0},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd1}},
      '{'{REQ_RSVD5,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF},  1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd1}},
      '{'{REQ_RSVD6,  32'hFFFF_FFFF, 32'd0,         16'd5},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd1}},
      '{'{REQ_RSVD7,  32'd0,         32'd0,         16'd0},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd1}},
      '{'{REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF},  1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd0}},
      '{'{REQ_GET,    32'hFFFF_FFFF, 32'd0,         16'd0},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd0}},
      '{'{REQ_SET,    32'd1,         32'd1,         16'd2},     1'b1,
        '{1'b0, 32'd0, 1'b0, 5'd1}},
      '{'{REQ_SET,    32'd2,         32'hDEAD_BEEF, 16'd0},     1'b0, '0},
      '{'{REQ_TICK,   32'd0,         32'd0,         16'd0},     1'b0, '0},
      '{'{REQ_GET,    32'd1,         32'd0,         16'd0},     1'b0, '0},
      '{'{REQ_SET,    32'd1,         32'h0F0F_0F0F, 16'hFFFF},  1'b0, '0},
      '{'{REQ_GET,    32'd2,         32'd0,         16'd0},     1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int find_slot(input logic [31:0] k);
      int s;
      s = -1;
      for (int i = DEPTH - 1; i >= 0; i--)
         if (cache_valid[i] && cache_key[i] == k) s = i;
      return s;
   endfunction

   // drop one entry and close the gap in insertion order
   function automatic void retire_slot(input int s);
      int r;
      r = cache_rank[s];
      cache_valid[s] = 1'b0;
      for (int i = 0; i < DEPTH; i++)
         if (cache_valid[i] && cache_rank[i] > r) cache_rank[i]--;
      if (cache_count > 0) cache_count--;
   endfunction

   function automatic rsp_item_type predict_response(input req_item_type r);
      rsp_item_type res;
      int           s;
      int           cap;
      int           oldest;
      logic [15:0]  life;
      logic [32:0]  sum;
      res = '0;
      case (r.op)
         REQ_TICK: begin
            if (now_ticks != '1) now_ticks = now_ticks + 32'd1;
         end
         REQ_SET: begin
            cap = (max_entries == 0) ? 1 : ((max_entries > DEPTH) ? DEPTH : int'(max_entries));
            s = find_slot(r.key);
            if (s >= 0) retire_slot(s);
            if (cache_count >= cap) begin
               oldest = -1;
               for (int i = 0; i < DEPTH; i++)
                  if (cache_valid[i] && (oldest < 0 || cache_rank[i] < cache_rank[oldest]))
                     oldest = i;
               if (oldest >= 0) begin
                  retire_slot(oldest);
                  res.evicted = 1'b1;
               end
            end
            s = -1;
            for (int i = DEPTH - 1; i >= 0; i--)
               if (!cache_valid[i]) s = i;
            if (s >= 0) begin
               life = (r.ttl != 0) ? r.ttl : fallback_ttl;
               sum = {1'b0, now_ticks} + {17'd0, life};
               cache_valid[s]  = 1'b1;
               cache_key[s]    = r.key;
               cache_value[s]  = r.value;
               cache_expiry[s] = sum[32] ? '1 : sum[31:0];
               cache_rank[s]   = cache_count;
               cache_count++;
            end
         end
         REQ_GET: begin
            s = find_slot(r.key);
            if (s >= 0) begin
               if (now_ticks > cache_expiry[s]) begin
                  retire_slot(s);
               end else begin
                  res.hit = 1'b1;
                  res.read_value = cache_value[s];
               end
            end
         end
         REQ_REMOVE: begin
            s = find_slot(r.key);
            if (s >= 0) retire_slot(s);
         end
         REQ_CLEAR: begin
            foreach (cache_valid[i]) cache_valid[i] = 1'b0;
            cache_count = 0;
         end
         default: ;
      endcase
      res.entry_count = cache_count[4:0];
      return res;
   endfunction

   task automatic report_failure(input string msg);
      if (mismatch_count < 10) $display("ERROR: %s", msg);
      mismatch_count++;
   endtask

   // valid stays high between back-to-back transfers; it drops only for an idle gap
   task automatic send_req(input req_item_type it, input logic typed,
                           input rsp_item_type typed_rsp);
      rsp_item_type predicted;
      if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= it.op;
      req_bus.key      <= it.key;
      req_bus.value    <= it.value;
      req_bus.ttl      <= it.ttl;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_response(it);
      expected_rsp_q.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic drain_responses();
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input logic [4:0] cap, input logic [15:0] ttl, input int src_pct,
                            input int snk_pct, input int n, input logic with_hold);
      req_item_type it;
      int           pick;
      req_bus.valid <= 1'b0;
      drain_responses();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAX_ENTRIES;
      csr_wdata <= {11'd0, cap};
      @(posedge clock);
      csr_index <= CSR_FALLBACK_TTL;
      csr_wdata <= ttl;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      max_entries = cap;
      fallback_ttl = ttl;
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      fork
         begin
            for (int i = 0; i < n; i++) begin
               pick     = $urandom_range(99);
               it.key   = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(23)];
               it.value = $urandom;
               case ($urandom_range(4))
                  0:       it.ttl = '0;
                  1, 2, 3: it.ttl = 16'($urandom_range(1, 6));
                  default: it.ttl = 16'($urandom);
               endcase
               if (pick < 26)      it.op = REQ_TICK;
               else if (pick < 58) it.op = REQ_SET;
               else if (pick < 88) it.op = REQ_GET;
               else if (pick < 95) it.op = REQ_REMOVE;
               else if (pick < 96) it.op = REQ_CLEAR;
               else begin
                  case ($urandom_range(2))
                     0:       it.op = REQ_RSVD5;
                     1:       it.op = REQ_RSVD6;
                     default: it.op = REQ_RSVD7;
                  endcase
               end
               send_req(it, 1'b0, '0);
            end
         end
         begin
            // long response stall so the block backs up onto its request side
            if (with_hold) begin
               repeat (10) @(posedge clock);
               hold_rsp <= 1'b1;
               repeat (400) @(posedge clock);
               hold_rsp <= 1'b0;
            end
         end
      join
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_rsp = '{rsp_bus.hit, rsp_bus.read_value, rsp_bus.evicted, rsp_bus.entry_count};
         if (expected_rsp_q.size() == 0) begin
            report_failure($sformatf("response with nothing pending: hit=%0d value=%h ev=%0d cnt=%0d",
                                     got_rsp.hit, got_rsp.read_value, got_rsp.evicted,
                                     got_rsp.entry_count));
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            if (got_rsp.hit !== want_rsp.hit || got_rsp.read_value !== want_rsp.read_value ||
                got_rsp.evicted !== want_rsp.evicted ||
                got_rsp.entry_count !== want_rsp.entry_count)
               report_failure($sformatf({"expected hit=%0d value=%h ev=%0d cnt=%0d, ",
                                         "got hit=%0d value=%h ev=%0d cnt=%0d"},
                                        want_rsp.hit, want_rsp.read_value, want_rsp.evicted,
                                        want_rsp.entry_count, got_rsp.hit, got_rsp.read_value,
                                        got_rsp.evicted, got_rsp.entry_count));
         end
      end
      rsp_bus.ready <= !hold_rsp && ($urandom_range(99) >= snk_idle_pct);
   end

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_TICK;
      req_bus.key      <= '0;
      req_bus.value    <= '0;
      req_bus.ttl      <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_MAX_ENTRIES;
      csr_wdata        <= '0;
      hold_rsp         <= 1'b0;
      foreach (cache_valid[i]) begin
         cache_valid[i]  = 1'b0;
         cache_key[i]    = '0;
         cache_value[i]  = '0;
         cache_expiry[i] = '0;
         cache_rank[i]   = 0;
      end
      cache_count = 0;
      now_ticks   = '0;
      max_entries = MAX_ENTRIES_RESET;
      fallback_ttl = FALLBACK_TTL_RESET;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 24; i++) key_pool[i] = $urandom;
      src_idle_pct = 19;
      snk_idle_pct = 72;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      run_phase(5'd4,  16'd5,      19, 72, 250, 1'b0);
      run_phase(5'd1,  16'd0,      19, 72, 200, 1'b0);
      run_phase(5'd0,  16'hFFFF,   19, 72, 150, 1'b0);
      run_phase(5'd16, 16'd3,      72, 19, 300, 1'b0);
      run_phase(5'd31, 16'd1,      72, 19, 200, 1'b0);
      // capacity dropped below a full table
      run_phase(5'd2,  16'd8,      72, 19, 150, 1'b0);
      run_phase(5'd17, 16'd4,       0,  0, 250, 1'b1);
      run_phase(5'd8,  16'h5A3C,    0,  0, 250, 1'b0);

      req_bus.valid <= 1'b0;
      drain_responses();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
